// ===== sv/dvrt_pkg.sv =====
// Package for the distance-vector route table unit.
// Holds sizes, item and result codes, controller states and the command/status
// structs shared by the controller, the datapath and the top level. No dependencies.
package dvrt_pkg;

    // Table geometry and result limits.
    localparam int TABLE_DEPTH = 32;
    localparam int MAX_RESULTS = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int NOUT_W      = $clog2(MAX_RESULTS);

    // Field widths.
    localparam int ADDR_W = 32;
    localparam int MET_W  = 9;

    // Configuration port.
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_INFINITY  = 2'd0;
    localparam logic [MET_W-1:0]   INFINITY_RESET = 9'd16;

    // Item kinds.
    typedef enum logic [1:0] {
        MODE_INSTALL = 2'd0,
        MODE_LEARN   = 2'd1,
        MODE_QUERY   = 2'd2,
        MODE_DUMP    = 2'd3
    } t_mode;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_DUMP  = 2'd2
    } t_kind;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SRC,
        S_DST,
        S_COMMIT,
        S_DUMP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan_start;
        logic key_src;
        logic latch_sum;
        logic commit;
        logic dump_start;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic dump_done;
        logic push_ok;
    } t_dp_sts;

endpackage

// ===== sv/distance_vector_route_table_unit.sv =====
// Top level of the distance-vector route table unit.
// Holds the configuration register and joins dvrt_ctrl and dvrt_dpath; depends on dvrt_pkg.
//
//  Channel   Handshake                  Payload
//  -------   -------------------------  ---------------------------------------------
//  in        i_in_valid / o_in_ready    i_mode, i_address, i_source_address,
//                                       i_advertised_metric, i_include_local
//  out       o_out_valid / i_out_ready  o_kind, o_entry_address, o_entry_metric,
//                                       o_entry_valid, o_table_full, o_last
//  config    psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// One item is handled at a time. The table is searched one slot per cycle through
// the memory read port over the N slots in use: once for install and query, and
// twice for learn (sender, then destination); a dump walks the slots the same way.
// Reset is synchronous and empties the table; no clearing pass is needed.
// A stalled output holds the result, and a dump pauses until the output register frees.
module distance_vector_route_table_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_mode,
    input  logic [dvrt_pkg::ADDR_W-1:0]     i_address,
    input  logic [dvrt_pkg::ADDR_W-1:0]     i_source_address,
    input  logic [dvrt_pkg::MET_W-1:0]      i_advertised_metric,
    input  logic                            i_include_local,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_kind,
    output logic [dvrt_pkg::ADDR_W-1:0]     o_entry_address,
    output logic [dvrt_pkg::MET_W-1:0]      o_entry_metric,
    output logic                            o_entry_valid,
    output logic                            o_table_full,
    output logic                            o_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dvrt_pkg::PADDR_W-1:0]    paddr,
    input  logic [dvrt_pkg::PDATA_W-1:0]    pwdata,
    output logic [dvrt_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import dvrt_pkg::*;

    logic [MET_W-1:0] r_inf;
    t_dp_cmd          cmd;
    t_dp_sts          sts;

    // Configuration register: written on the access phase of an APB transfer.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inf <= INFINITY_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_INFINITY)) begin
            r_inf <= pwdata[MET_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_INFINITY) ? {{(PDATA_W - MET_W){1'b0}}, r_inf} : '0;

    // Controller.
    dvrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Datapath.
    dvrt_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_inf               (r_inf),
        .i_mode              (i_mode),
        .i_address           (i_address),
        .i_source_address    (i_source_address),
        .i_advertised_metric (i_advertised_metric),
        .i_include_local     (i_include_local),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_kind              (o_kind),
        .o_entry_address     (o_entry_address),
        .o_entry_metric      (o_entry_metric),
        .o_entry_valid       (o_entry_valid),
        .o_table_full        (o_table_full),
        .o_last              (o_last)
    );

`ifndef SYNTH
    // An accepted item keeps the input closed on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a transfer");

    // A full-table result is an install or learn acknowledgment without an entry.
    a_full_is_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_table_full) |-> (!o_entry_valid && (o_kind == KIND_ACK)))
        else $error("table full flagged on a wrong result");

    // Only dump entries may be followed by further results of the same item.
    a_not_last_is_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_kind == KIND_DUMP))
        else $error("non-final result outside a dump");
`endif

endmodule

// ===== sv/dvrt_ctrl.sv =====
// Controller state machine of the route table unit.
// Sequences lookups, the commit step and table dumps; depends on dvrt_pkg.
module dvrt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_mode,
    input  dvrt_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output dvrt_pkg::t_dp_cmd o_cmd
);
    import dvrt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_mode'(i_mode)) inside
                        MODE_LEARN:               n_state = S_SRC;
                        MODE_DUMP:                n_state = S_DUMP;
                        MODE_INSTALL, MODE_QUERY: n_state = S_DST;
                        default:                  n_state = S_DST;
                    endcase
                end
            end
            S_SRC: begin
                if (i_sts.scan_done) n_state = S_DST;
            end
            S_DST: begin
                if (i_sts.scan_done) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.push_ok) n_state = S_IDLE;
            end
            S_DUMP: begin
                if (i_sts.dump_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = accept;
                if (accept) begin
                    unique case (t_mode'(i_mode)) inside
                        MODE_LEARN: begin
                            o_cmd.scan_start = 1'b1;
                            o_cmd.key_src    = 1'b1;
                        end
                        MODE_DUMP:                o_cmd.dump_start = 1'b1;
                        MODE_INSTALL, MODE_QUERY: o_cmd.scan_start = 1'b1;
                        default:                  o_cmd.scan_start = 1'b1;
                    endcase
                end
            end
            S_SRC: begin
                // The sender's metric is known: keep the sum and look up the destination.
                if (i_sts.scan_done) begin
                    o_cmd.latch_sum  = 1'b1;
                    o_cmd.scan_start = 1'b1;
                end
            end
            S_COMMIT: o_cmd.commit = i_sts.push_ok;
            S_DST, S_DUMP: ;
            default: ;
        endcase
    end

endmodule

// ===== sv/dvrt_dpath.sv =====
// Datapath of the route table unit: the address and metric memories, the
// sequential scan engine, the metric update and the output register. Depends on dvrt_pkg.
module dvrt_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dvrt_pkg::t_dp_cmd               i_cmd,
    output dvrt_pkg::t_dp_sts               o_sts,
    input  logic [dvrt_pkg::MET_W-1:0]      i_inf,
    input  logic [1:0]                      i_mode,
    input  logic [dvrt_pkg::ADDR_W-1:0]     i_address,
    input  logic [dvrt_pkg::ADDR_W-1:0]     i_source_address,
    input  logic [dvrt_pkg::MET_W-1:0]      i_advertised_metric,
    input  logic                            i_include_local,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [1:0]                      o_kind,
    output logic [dvrt_pkg::ADDR_W-1:0]     o_entry_address,
    output logic [dvrt_pkg::MET_W-1:0]      o_entry_metric,
    output logic                            o_entry_valid,
    output logic                            o_table_full,
    output logic                            o_last
);
    import dvrt_pkg::*;

    localparam logic [NOUT_W-1:0] NOUT_LAST = NOUT_W'(MAX_RESULTS - 1);
    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // Table memories; only slots below the fill count are ever read for a decision.
    logic [ADDR_W-1:0] r_addr_mem   [TABLE_DEPTH];
    logic [MET_W-1:0]  r_metric_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0] r_rd_addr;
    logic [MET_W-1:0]  r_rd_metric;

    // Latched item.
    t_mode             r_mode;
    logic [ADDR_W-1:0] r_address;
    logic [ADDR_W-1:0] r_source;
    logic [MET_W-1:0]  r_adv;
    logic              r_incl;

    // Scan engine.
    logic              r_scan;
    logic              r_dump;
    logic [ADDR_W-1:0] r_key;
    logic [CNT_W-1:0]  r_idx;
    logic              r_pend;
    logic [IDX_W-1:0]  r_pidx;
    logic [CNT_W-1:0]  r_count;

    // Lookup results and the learned sum.
    logic              r_hit;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [MET_W-1:0]  r_hit_metric;
    logic [MET_W-1:0]  r_sum;

    // Dump look-ahead entry and result count.
    logic              r_hold_v;
    logic [ADDR_W-1:0] r_hold_addr;
    logic [MET_W-1:0]  r_hold_metric;
    logic [NOUT_W-1:0] r_nout;

    // Output register.
    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [ADDR_W-1:0] r_out_addr;
    logic [MET_W-1:0]  r_out_metric;
    logic              r_out_evalid;
    logic              r_out_full;
    logic              r_out_last;

    logic              match;
    logic              qual;
    logic              more;
    logic              push_ok;
    logic              hit_now;
    logic              lookup_done;
    logic              fin;
    logic              dump_fin_push;
    logic              dump_mid_push;
    logic              hold_load;
    logic              advance;
    logic [IDX_W-1:0]  rd_idx;
    logic [ADDR_W-1:0] key;
    logic [MET_W-1:0]  via;
    logic [MET_W:0]    sum_wide;
    logic [MET_W-1:0]  sum_sat;
    logic              is_query;
    logic              tbl_room;
    logic              is_new;
    logic              is_full;
    logic [MET_W-1:0]  stored;
    logic [IDX_W-1:0]  w_idx;
    logic [MET_W-1:0]  new_metric;
    logic              out_push;

    // Scan compare: the read data belongs to slot r_pidx when r_pend is set.
    assign match   = (r_rd_addr == r_key);
    assign qual    = (r_rd_metric != '0) || r_incl;
    assign more    = (r_idx < r_count);
    assign push_ok = !r_out_valid || i_out_ready;
    assign hit_now = r_pend && match;

    assign lookup_done = r_scan && !r_dump && (hit_now || (!r_pend && !more));

    // A dump ends when the table is exhausted or the result limit is reached.
    assign fin           = (r_hold_v && (r_nout == NOUT_LAST)) || (!r_pend && !more);
    assign dump_fin_push = r_scan && r_dump && fin && push_ok;
    assign dump_mid_push = r_scan && r_dump && !fin && r_pend && qual && r_hold_v && push_ok;
    assign hold_load     = r_scan && r_dump && !fin && r_pend && qual && (!r_hold_v || push_ok);
    assign advance       = !(r_scan && r_dump &&
                             (fin || (r_pend && qual && r_hold_v && !push_ok)));

    // A stalled dump rereads the same slot so the read data holds.
    assign rd_idx = advance ? r_idx[IDX_W-1:0] : r_pidx;

    // Search key comes straight from the ports on the transfer cycle, else from the latched item.
    always_comb begin
        if (i_cmd.key_src) begin
            key = i_cmd.accept ? i_source_address : r_source;
        end else begin
            key = i_cmd.accept ? i_address : r_address;
        end
    end

    // Advertised metric plus metric to the sender, saturating at infinity.
    assign via      = hit_now ? r_rd_metric : i_inf;
    assign sum_wide = {1'b0, r_adv} + {1'b0, via};
    assign sum_sat  = (sum_wide > {1'b0, i_inf}) ? i_inf : sum_wide[MET_W-1:0];

    // Commit step: existing slot, new slot at infinity, or a full table.
    assign is_query   = (r_mode == MODE_QUERY);
    assign tbl_room   = (r_count < DEPTH_CNT);
    assign is_new     = !r_hit && tbl_room;
    assign is_full    = !r_hit && !tbl_room;
    assign stored     = r_hit ? r_hit_metric : i_inf;
    assign w_idx      = r_hit ? r_hit_idx : r_count[IDX_W-1:0];
    assign new_metric = (r_mode == MODE_INSTALL) ? '0 :
                        ((r_sum < stored) ? r_sum : stored);

    assign out_push = i_cmd.commit || dump_mid_push || dump_fin_push;

    assign o_sts.scan_done = lookup_done;
    assign o_sts.dump_done = dump_fin_push;
    assign o_sts.push_ok   = push_ok;

    // Memory read and write ports.
    always_ff @(posedge i_clk) begin
        r_rd_addr   <= r_addr_mem[rd_idx];
        r_rd_metric <= r_metric_mem[rd_idx];
        if (i_cmd.commit && !is_query && !is_full) begin
            r_metric_mem[w_idx] <= new_metric;
            if (is_new) begin
                r_addr_mem[w_idx] <= r_address;
            end
        end
    end

    // Control state of the scan engine, fill count and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= 1'b0;
            r_dump      <= 1'b0;
            r_pend      <= 1'b0;
            r_hold_v    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (out_push) r_out_valid <= 1'b1;
            if (r_scan && advance) r_pend <= more;
            if (lookup_done || dump_fin_push) r_scan <= 1'b0;
            if (hold_load) r_hold_v <= 1'b1;
            if (dump_fin_push) r_hold_v <= 1'b0;
            if (i_cmd.commit && !is_query && is_new) r_count <= r_count + 1'b1;
            if (i_cmd.scan_start) begin
                r_scan <= 1'b1;
                r_dump <= 1'b0;
                r_pend <= 1'b0;
            end
            if (i_cmd.dump_start) begin
                r_scan   <= 1'b1;
                r_dump   <= 1'b1;
                r_pend   <= 1'b0;
                r_hold_v <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode    <= t_mode'(i_mode);
            r_address <= i_address;
            r_source  <= i_source_address;
            r_adv     <= i_advertised_metric;
            r_incl    <= i_include_local;
        end
        if (r_scan && advance && more) begin
            r_pidx <= r_idx[IDX_W-1:0];
            r_idx  <= r_idx + 1'b1;
        end
        if (i_cmd.scan_start || i_cmd.dump_start) begin
            r_idx  <= '0;
            r_key  <= key;
            r_nout <= '0;
        end
        if (lookup_done) begin
            r_hit        <= hit_now;
            r_hit_idx    <= r_pidx;
            r_hit_metric <= r_rd_metric;
        end
        if (i_cmd.latch_sum) r_sum <= sum_sat;
        if (hold_load) begin
            r_hold_addr   <= r_rd_addr;
            r_hold_metric <= r_rd_metric;
        end
        if (dump_mid_push) r_nout <= r_nout + 1'b1;

        // Result selection.
        if (i_cmd.commit) begin
            r_out_kind <= is_query ? KIND_QUERY : KIND_ACK;
            r_out_addr <= r_address;
            if (is_query) begin
                r_out_metric <= r_hit ? r_hit_metric : i_inf;
                r_out_evalid <= r_hit;
                r_out_full   <= 1'b0;
            end else begin
                r_out_metric <= is_full ? i_inf : new_metric;
                r_out_evalid <= !is_full;
                r_out_full   <= is_full;
            end
            r_out_last <= 1'b1;
        end else if (dump_mid_push) begin
            r_out_kind   <= KIND_DUMP;
            r_out_addr   <= r_hold_addr;
            r_out_metric <= r_hold_metric;
            r_out_evalid <= 1'b1;
            r_out_full   <= 1'b0;
            r_out_last   <= 1'b0;
        end else if (dump_fin_push) begin
            r_out_kind   <= KIND_DUMP;
            r_out_addr   <= r_hold_v ? r_hold_addr : '0;
            r_out_metric <= r_hold_v ? r_hold_metric : '0;
            r_out_evalid <= r_hold_v;
            r_out_full   <= 1'b0;
            r_out_last   <= 1'b1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_entry_address = r_out_addr;
    assign o_entry_metric  = r_out_metric;
    assign o_entry_valid   = r_out_evalid;
    assign o_table_full    = r_out_full;
    assign o_last          = r_out_last;

endmodule
